FILE: sv/fkth_pkg.sv
// ----------------------------------------------------------------------------
// fkth_pkg
// Constants for the flow key and time tag pipeline.
// ----------------------------------------------------------------------------
package fkth_pkg;

  localparam int unsigned NumStages = 8;

  localparam logic [63:0] HashMult   = 64'd2862933555777941757;
  localparam logic [31:0] HashMultLo = HashMult[31:0];
  localparam logic [31:0] HashMultHi = HashMult[63:32];

  localparam int unsigned TimeBits = 24;
  localparam int unsigned HashBits = 64 - TimeBits;

  localparam logic ADDR_FAMILY_IPV4 = 1'b0;
  localparam logic ADDR_FAMILY_IPV6 = 1'b1;

  typedef logic [NumStages-1:0] stage_valid_t;

endpackage

FILE: sv/flow_key_time_hash.sv
// ----------------------------------------------------------------------------
// flow_key_time_hash
// Hashes one IPv4 or IPv6 flow key and joins the top 40 hash bits with the
// low 24 bits of a time in seconds.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------
//   key in  | item_valid, item_stall  | addr_family, src/dst words, ports,
//           |                         | protocol, time_sec
//   tag out | tag_valid, tag_stall    | flow_tag
//
// eight register stages, one beat a cycle while the output is not stalled
// the two 64-bit modular multiplies by the hash constant set the depth
// reset clears only the stage valid bits
// a stalled output holds the whole pipe, so input stall follows it
// ----------------------------------------------------------------------------
module flow_key_time_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        addr_family,
  input  logic [63:0] src_word_a,
  input  logic [63:0] src_word_b,
  input  logic [63:0] dst_word_a,
  input  logic [63:0] dst_word_b,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  protocol,
  input  logic [31:0] time_sec,
  output logic        tag_valid,
  input  logic        tag_stall,
  output logic [63:0] flow_tag
);
  import fkth_pkg::*;

  fkth_pkg::stage_valid_t vld;
  logic adv;

  // stage 1
  logic                s1_fam;
  logic [15:0]         s1_sp, s1_dp;
  logic [TimeBits-1:0] s1_tm;
  logic [63:0]         s1_sum;
  logic [63:0]         s1_dll, s1_sll;
  logic [31:0]         s1_dlh, s1_dhl, s1_slh, s1_shl;
  logic [47:0]         s1_spda, s1_dpsa;
  // stage 2
  logic                s2_fam;
  logic [15:0]         s2_sp, s2_dp;
  logic [TimeBits-1:0] s2_tm;
  logic [63:0]         s2_sum, s2_pd, s2_ps, s2_t4;
  // stage 3
  logic                s3_fam;
  logic [TimeBits-1:0] s3_tm;
  logic [63:0]         s3_sum, s3_t4;
  logic [47:0]         s3_sppl, s3_dppl;
  logic [31:0]         s3_spph, s3_dpph;
  // stage 4
  logic [TimeBits-1:0] s4_tm;
  logic [63:0]         s4_sum, s4_term;
  // stage 5
  logic [TimeBits-1:0] s5_tm;
  logic [63:0]         s5_sum, s5_ll;
  logic [31:0]         s5_lh, s5_hl;
  // stage 6
  logic [TimeBits-1:0] s6_tm;
  logic [63:0]         s6_h1;
  // stage 7
  logic [TimeBits-1:0] s7_tm;
  logic [63:0]         s7_ll;
  logic [31:0]         s7_lh, s7_hl;

  // combinational products and sums
  logic [63:0] p_dll, p_dlh, p_dhl, p_sll, p_slh, p_shl;
  logic [47:0] p_spda, p_dpsa;
  logic [31:0] sum4;
  logic [63:0] sum6, sum_next;
  logic [47:0] p_sppl, p_dppl, p_spph, p_dpph;
  logic [63:0] term_next;
  logic [63:0] p_ll, p_lh, p_hl, q_ll, q_lh, q_hl;

  assign adv        = !vld[NumStages-1] || !tag_stall;
  assign item_stall = !adv;
  assign tag_valid  = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], item_valid};
    end
  end

  always_comb begin
    p_dll  = 64'(dst_word_a[31:0]) * 64'(dst_word_b[31:0]);
    p_dlh  = 64'(dst_word_a[31:0]) * 64'(dst_word_b[63:32]);
    p_dhl  = 64'(dst_word_a[63:32]) * 64'(dst_word_b[31:0]);
    p_sll  = 64'(src_word_a[31:0]) * 64'(src_word_b[31:0]);
    p_slh  = 64'(src_word_a[31:0]) * 64'(src_word_b[63:32]);
    p_shl  = 64'(src_word_a[63:32]) * 64'(src_word_b[31:0]);
    p_spda = 48'(source_port) * 48'(dst_word_a[31:0]);
    p_dpsa = 48'(dest_port) * 48'(src_word_a[31:0]);
    sum4   = src_word_a[31:0] + dst_word_a[31:0] + 32'(source_port) + 32'(dest_port)
           + 32'(protocol);
    sum6   = src_word_a + src_word_b + dst_word_a + dst_word_b + 64'(source_port)
           + 64'(dest_port) + 64'(protocol);
    sum_next = (addr_family == ADDR_FAMILY_IPV6) ? sum6 : 64'(sum4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fam  <= addr_family;
      s1_sp   <= source_port;
      s1_dp   <= dest_port;
      s1_tm   <= time_sec[TimeBits-1:0];
      s1_sum  <= sum_next;
      s1_dll  <= p_dll;
      s1_dlh  <= p_dlh[31:0];
      s1_dhl  <= p_dhl[31:0];
      s1_sll  <= p_sll;
      s1_slh  <= p_slh[31:0];
      s1_shl  <= p_shl[31:0];
      s1_spda <= p_spda;
      s1_dpsa <= p_dpsa;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fam <= s1_fam;
      s2_sp  <= s1_sp;
      s2_dp  <= s1_dp;
      s2_tm  <= s1_tm;
      s2_sum <= s1_sum;
      s2_pd  <= s1_dll + {s1_dlh + s1_dhl, 32'd0};
      s2_ps  <= s1_sll + {s1_slh + s1_shl, 32'd0};
      s2_t4  <= 64'(s1_spda) + 64'(s1_dpsa);
    end
  end

  always_comb begin
    p_sppl = 48'(s2_sp) * 48'(s2_pd[31:0]);
    p_spph = 48'(s2_sp) * 48'(s2_pd[63:32]);
    p_dppl = 48'(s2_dp) * 48'(s2_ps[31:0]);
    p_dpph = 48'(s2_dp) * 48'(s2_ps[63:32]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fam  <= s2_fam;
      s3_tm   <= s2_tm;
      s3_sum  <= s2_sum;
      s3_t4   <= s2_t4;
      s3_sppl <= p_sppl;
      s3_spph <= p_spph[31:0];
      s3_dppl <= p_dppl;
      s3_dpph <= p_dpph[31:0];
    end
  end

  always_comb begin
    if (s3_fam == ADDR_FAMILY_IPV6) begin
      term_next = 64'(s3_sppl) + 64'(s3_dppl) + {s3_spph + s3_dpph, 32'd0};
    end else begin
      term_next = s3_t4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tm   <= s3_tm;
      s4_sum  <= s3_sum;
      s4_term <= term_next;
    end
  end

  // first multiply by the hash constant
  always_comb begin
    p_ll = 64'(s4_term[31:0]) * 64'(HashMultLo);
    p_lh = 64'(s4_term[31:0]) * 64'(HashMultHi);
    p_hl = 64'(s4_term[63:32]) * 64'(HashMultLo);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tm  <= s4_tm;
      s5_sum <= s4_sum;
      s5_ll  <= p_ll;
      s5_lh  <= p_lh[31:0];
      s5_hl  <= p_hl[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tm <= s5_tm;
      s6_h1 <= s5_ll + {s5_lh + s5_hl, 32'd0} + s5_sum;
    end
  end

  // second multiply by the hash constant
  always_comb begin
    q_ll = 64'(s6_h1[31:0]) * 64'(HashMultLo);
    q_lh = 64'(s6_h1[31:0]) * 64'(HashMultHi);
    q_hl = 64'(s6_h1[63:32]) * 64'(HashMultLo);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_tm <= s6_tm;
      s7_ll <= q_ll;
      s7_lh <= q_lh[31:0];
      s7_hl <= q_hl[31:0];
    end
  end

  logic [63:0] h2;
  assign h2 = s7_ll + {s7_lh + s7_hl, 32'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      flow_tag <= {h2[63:TimeBits], s7_tm};
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> vld[0])
    else $error("accepted beat missing from first stage");

  a_hold_valids: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valids moved during stall");

  a_hold_tag: assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_stall |=> tag_valid && $stable(flow_tag))
    else $error("stalled tag changed or dropped");

endmodule

FILE: test/tb_flow_key_time_hash.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flow_key_time_hash
// Self-checking bench for the flow key and time tag pipeline. A short table
// of directed keys covers zero, all-ones and ignored-bit cases for both
// address families. Random IPv4 and IPv6 keys follow. Every accepted key is
// predicted in the bench and compared with the tag that leaves the pipe, in
// order. Both sides insert random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_flow_key_time_hash;
  import fkth_pkg::*;

  localparam logic [63:0] KEY_MULT     = 64'd2862933555777941757;
  localparam int          RANDOM_KEYS  = 1280;
  localparam int          STEADY_KEYS  = 200;
  localparam int          PAUSE_AT     = 600;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          NUM_ROWS     = 21;

  typedef struct packed {
    logic        family;
    logic [63:0] src_a;
    logic [63:0] src_b;
    logic [63:0] dst_a;
    logic [63:0] dst_b;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [31:0] secs;
  } flow_key_t;

  typedef struct packed {
    flow_key_t   key;
    logic        known;
    logic [63:0] tag;
  } key_row_t;

  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] HIGH_ONLY = 64'hffff_ffff_0000_0000;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALT_A = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic [63:0] ALT_5 = 64'h5555_5555_5555_5555;

  // family, src a/b, dst a/b, ports, protocol, time, known, tag
  localparam key_row_t KEY_TABLE [NUM_ROWS] = '{
    '{'{ADDR_FAMILY_IPV4, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'd0, 32'd0},
      1'b1, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'd0,
        32'hffff_ffff}, 1'b1, 64'h0000_0000_00ff_ffff},
    '{'{ADDR_FAMILY_IPV4, HIGH_ONLY, ONES, HIGH_ONLY, ONES, 16'd0, 16'd0, 8'd0,
        32'h1234_5678}, 1'b1, 64'h0000_0000_0034_5678},
    '{'{ADDR_FAMILY_IPV6, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'd0,
        32'hff00_0000}, 1'b1, 64'd0},
    '{'{ADDR_FAMILY_IPV4, ONES, ONES, ONES, ONES, 16'hffff, 16'hffff, 8'hff,
        32'hffff_ffff}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, ONES, ONES, ONES, ONES, 16'hffff, 16'hffff, 8'hff,
        32'hffff_ffff}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'hffff_ffff, 64'd0, 64'hffff_ffff, 64'd0, 16'hffff,
        16'hffff, 8'hff, 32'd0}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'd1, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'd0,
        32'd1}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'd0, 64'd0, 64'hffff_ffff, 64'd0, 16'hffff, 16'd0,
        8'd0, 32'd2}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'hffff_ffff, 64'd0, 64'd0, 64'd0, 16'd0, 16'hffff,
        8'd0, 32'd3}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'hff,
        32'd4}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'hff,
        32'd5}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, ONES, ONES, 64'd0, 64'd0, 16'd0, 16'hffff, 8'd0,
        32'd6}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, 64'd0, 64'd0, ONES, ONES, 16'hffff, 16'd0, 8'd0,
        32'd7}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, ONES, 64'd0, ONES, 64'd0, 16'hffff, 16'hffff, 8'd0,
        32'd8}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, 64'd0, ONES, 64'd0, ONES, 16'hffff, 16'hffff, 8'd0,
        32'd9}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, TOP_BIT, TOP_BIT, TOP_BIT, TOP_BIT, 16'h8000, 16'h8000,
        8'h80, 32'h8000_0000}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, 64'hdead_beef_0a00_0001, 64'h0123_4567_89ab_cdef,
        64'hffff_ffff_c0a8_0101, 64'hfedc_ba98_7654_3210, 16'd443, 16'd51000,
        8'd6, 32'h6543_2100}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_0042,
        64'hfe80_0000_0000_0000, 64'h0211_22ff_fe33_4455, 16'd53, 16'd1024,
        8'd17, 32'h00ab_cdef}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV4, ALT_A, ALT_5, ALT_5, ALT_A, 16'haaaa, 16'h5555, 8'haa,
        32'h5555_5555}, 1'b0, 64'd0},
    '{'{ADDR_FAMILY_IPV6, ALT_A, ALT_5, ALT_5, ALT_A, 16'h5555, 16'haaaa, 8'h55,
        32'haaaa_aaaa}, 1'b0, 64'd0}
  };

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        addr_family;
  logic [63:0] src_word_a;
  logic [63:0] src_word_b;
  logic [63:0] dst_word_a;
  logic [63:0] dst_word_b;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol;
  logic [31:0] time_sec;
  logic        tag_valid;
  logic        tag_stall;
  logic [63:0] flow_tag;

  logic [63:0] pending_tags[$];
  logic [63:0] oldest_tag;
  int          mismatch_count = 0;
  int          quiet_cycles;
  int          stall_left;
  logic        steady_tail;

  flow_key_time_hash uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .addr_family (addr_family),
    .src_word_a  (src_word_a),
    .src_word_b  (src_word_b),
    .dst_word_a  (dst_word_a),
    .dst_word_b  (dst_word_b),
    .source_port (source_port),
    .dest_port   (dest_port),
    .protocol    (protocol),
    .time_sec    (time_sec),
    .tag_valid   (tag_valid),
    .tag_stall   (tag_stall),
    .flow_tag    (flow_tag)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // key hash: ((term * mult) + sum) * mult, top 40 bits joined with time
  function automatic logic [63:0] flow_tag_of(input flow_key_t k);
    logic [63:0] sa;
    logic [63:0] da;
    logic [63:0] sp;
    logic [63:0] dp;
    logic [63:0] pr;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] h;
    sp = {48'd0, k.sport};
    dp = {48'd0, k.dport};
    pr = {56'd0, k.proto};
    if (k.family == ADDR_FAMILY_IPV4) begin
      sa = {32'd0, k.src_a[31:0]};
      da = {32'd0, k.dst_a[31:0]};
      term = sp * da + dp * sa;
      sum = sa + da + sp + dp + pr;
      sum = {32'd0, sum[31:0]};
    end else begin
      term = sp * k.dst_a * k.dst_b + dp * k.src_a * k.src_b;
      sum = k.src_a + k.src_b + k.dst_a + k.dst_b + sp + dp + pr;
    end
    h = term * KEY_MULT + sum;
    h = h * KEY_MULT;
    return {h[63:24], k.secs[23:0]};
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic flow_key_t rand_key();
    flow_key_t k;
    k.family = $urandom_range(0, 1) ? ADDR_FAMILY_IPV6 : ADDR_FAMILY_IPV4;
    k.src_a = rand_word();
    k.src_b = rand_word();
    k.dst_a = rand_word();
    k.dst_b = rand_word();
    k.sport = rand_port();
    k.dport = rand_port();
    k.proto = 8'($urandom);
    k.secs = $urandom;
    return k;
  endfunction

  task automatic send_key(input flow_key_t k, input logic [63:0] want);
    item_valid  <= 1'b1;
    addr_family <= k.family;
    src_word_a  <= k.src_a;
    src_word_b  <= k.src_b;
    dst_word_a  <= k.dst_a;
    dst_word_b  <= k.dst_b;
    source_port <= k.sport;
    dest_port   <= k.dport;
    protocol    <= k.proto;
    time_sec    <= k.secs;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_tags.push_back(want);
  endtask

  task automatic maybe_idle();
    if (!steady_tail && $urandom_range(0, 9) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    addr_family = ADDR_FAMILY_IPV4;
    src_word_a  = '0;
    src_word_b  = '0;
    dst_word_a  = '0;
    dst_word_b  = '0;
    source_port = '0;
    dest_port   = '0;
    protocol    = '0;
    time_sec    = '0;
    steady_tail = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_key(KEY_TABLE[i].key,
               KEY_TABLE[i].known ? KEY_TABLE[i].tag : flow_tag_of(KEY_TABLE[i].key));
      maybe_idle();
    end

    for (int i = 0; i < RANDOM_KEYS; i++) begin
      flow_key_t k;
      if (i == PAUSE_AT) begin
        // hold off until the pipe has drained
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_tags.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_KEYS - STEADY_KEYS) steady_tail = 1'b1;
      k = rand_key();
      send_key(k, flow_tag_of(k));
      maybe_idle();
    end

    item_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output side: random stall bursts, in-order tag check
  always @(posedge clk) begin
    if (rst) begin
      tag_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (tag_valid && !tag_stall) begin
        if (pending_tags.size() == 0) begin
          $error("flow_tag: expected none, actual %h", flow_tag);
          mismatch_count++;
        end else begin
          oldest_tag = pending_tags.pop_front();
          if (flow_tag !== oldest_tag) begin
            $error("flow_tag: expected %h, actual %h", oldest_tag, flow_tag);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!steady_tail && $urandom_range(0, 11) == 0) begin
        tag_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 17);
      end else begin
        tag_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (tag_valid && !tag_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
